// File: src/rbe_pkg.sv
`default_nettype none

package rbe_pkg;

    // Token bytes and control codes
    localparam logic [7:0] TOK_ABS       = 8'h00;
    localparam logic [7:0] TOK_ESCAPE    = 8'h80;
    localparam logic [7:0] TOK_PAD       = 8'hFE;
    localparam logic [3:0] CODE_END      = 4'd15;
    localparam logic [3:0] CODE_PAD      = 4'd14;
    localparam logic [3:0] CODE_AFIELD   = 4'd5;
    localparam logic [3:0] CODE_NAME_MAX = 4'd8;

    localparam logic [3:0] MAX_RUN  = 4'd8;
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Field lengths in bits
    localparam logic [4:0] LEN_TAG   = 5'd1;
    localparam logic [4:0] LEN_TYPE  = 5'd2;
    localparam logic [4:0] LEN_CODE  = 5'd4;
    localparam logic [4:0] LEN_BYTE  = 5'd8;
    localparam logic [4:0] LEN_WORD  = 5'd16;
    localparam logic [4:0] LEN_COUNT = 5'd3;

    typedef enum logic [3:0] {
        PH_TAG,
        PH_ABS,
        PH_TYPE,
        PH_REL,
        PH_CTRL,
        PH_ATYPE,
        PH_AVAL,
        PH_LEN,
        PH_NAME
    } phase_t;

    // Token sequence raised by a completed field
    typedef enum logic [2:0] {
        SEQ_NONE,
        SEQ_ZERO,
        SEQ_ONE,
        SEQ_REL,
        SEQ_CTRL,
        SEQ_END,
        SEQ_AVAL,
        SEQ_PAD
    } seq_t;

    // Source of one emitted byte
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_LO,
        SRC_HI,
        SRC_ATYPE,
        SRC_SPECIAL,
        SRC_PAD,
        SRC_RAW,
        SRC_CNT
    } src_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       emit;
        logic       flush;
        logic [2:0] bit_sel;
        src_t       src;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic stopped;
        logic emit_ok;
        logic flush_ok;
        seq_t seq;
    } stat_t;

endpackage

`default_nettype wire

// File: src/rbe_datapath.sv
`default_nettype none

module rbe_datapath
    import rbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire cmd_t       cmd,
    output stat_t           stat,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            finished
);

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [4:0]  left_reg, left_next;
    logic [15:0] fld_reg, fld_next;
    logic [3:0]  code_reg, code_next;
    logic [1:0]  atype_reg, atype_next;
    logic [2:0]  name_reg, name_next;
    logic [7:0]  raw_reg, raw_next;
    logic        stopped_reg, stopped_next;
    logic [3:0]  run_cnt_reg, run_cnt_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        pend_fin_reg, pend_fin_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_fin_reg, out_fin_next;

    logic        cur_bit;
    logic [15:0] acc_shift;
    logic        complete;
    phase_t      nph;
    logic [4:0]  nbits;
    seq_t        seq;
    logic [2:0]  name_dec;
    logic [2:0]  cnt;
    logic [7:0]  emit_byte;
    logic        out_free;
    logic        capped;
    logic        push;
    logic        do_flush;

    always_comb
    begin
        cur_bit   = raw_reg[LAST_BIT - cmd.bit_sel];
        acc_shift = {acc_reg[14:0], cur_bit};
        complete  = (left_reg <= 5'd1);
        name_dec  = (name_reg == 3'd0) ? 3'd0 : name_reg - 3'd1;
        cnt       = cmd.bit_sel + 3'd1;

        nph        = PH_TAG;
        nbits      = LEN_TAG;
        seq        = SEQ_NONE;
        code_next  = code_reg;
        atype_next = atype_reg;
        name_next  = name_reg;
        stopped_next = stopped_reg;

        case (phase_reg)
            PH_TAG:
            begin
                if (!cur_bit)
                begin
                    seq   = SEQ_ZERO;
                    nph   = PH_ABS;
                    nbits = LEN_BYTE;
                end
                else
                begin
                    nph   = PH_TYPE;
                    nbits = LEN_TYPE;
                end
            end
            PH_ABS:
                seq = SEQ_ONE;
            PH_TYPE:
            begin
                if (acc_shift[1:0] != 2'd0)
                begin
                    atype_next = acc_shift[1:0];
                    seq        = SEQ_ONE;
                    nph        = PH_REL;
                    nbits      = LEN_WORD;
                end
                else
                begin
                    nph   = PH_CTRL;
                    nbits = LEN_CODE;
                end
            end
            PH_REL:
                seq = SEQ_REL;
            PH_CTRL:
            begin
                code_next = acc_shift[3:0];
                if (acc_shift[3:0] == CODE_END)
                begin
                    seq          = SEQ_END;
                    stopped_next = 1'b1;
                end
                else if (acc_shift[3:0] >= CODE_AFIELD)
                begin
                    seq   = SEQ_CTRL;
                    nph   = PH_ATYPE;
                    nbits = LEN_TYPE;
                end
                else
                begin
                    seq   = SEQ_CTRL;
                    nph   = PH_LEN;
                    nbits = LEN_COUNT;
                end
            end
            PH_ATYPE:
            begin
                atype_next = acc_shift[1:0];
                nph        = PH_AVAL;
                nbits      = LEN_WORD;
            end
            PH_AVAL:
            begin
                if (code_reg == CODE_PAD)
                    seq = SEQ_PAD;
                else
                begin
                    seq = SEQ_AVAL;
                    if (code_reg <= CODE_NAME_MAX)
                    begin
                        nph   = PH_LEN;
                        nbits = LEN_COUNT;
                    end
                end
            end
            PH_LEN:
            begin
                name_next = acc_shift[2:0];
                seq       = SEQ_ONE;
                if (acc_shift[2:0] != 3'd0)
                begin
                    nph   = PH_NAME;
                    nbits = LEN_BYTE;
                end
            end
            PH_NAME:
            begin
                name_next = name_dec;
                seq       = SEQ_ONE;
                if (name_dec != 3'd0)
                begin
                    nph   = PH_NAME;
                    nbits = LEN_BYTE;
                end
            end
            default:
            begin
                nph   = PH_TAG;
                nbits = LEN_TAG;
            end
        endcase

        // Field still filling: no decode, no side effects
        if (!cmd.step || !complete)
        begin
            seq          = SEQ_NONE;
            code_next    = code_reg;
            atype_next   = atype_reg;
            name_next    = name_reg;
            stopped_next = stopped_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        fld_next   = fld_reg;
        raw_next   = raw_reg;

        if (cmd.load)
            raw_next = in_byte;

        if (cmd.step)
        begin
            if (complete)
            begin
                phase_next = nph;
                acc_next   = 16'd0;
                left_next  = nbits;
                fld_next   = acc_shift;
            end
            else
            begin
                acc_next  = acc_shift;
                left_next = left_reg - 5'd1;
            end
        end
    end

    always_comb
    begin
        case (cmd.src)
            SRC_ZERO:    emit_byte = TOK_ABS;
            SRC_LO:      emit_byte = fld_reg[7:0];
            SRC_HI:      emit_byte = fld_reg[15:8];
            SRC_ATYPE:   emit_byte = {6'd0, atype_reg};
            SRC_SPECIAL: emit_byte = TOK_ESCAPE;
            SRC_PAD:     emit_byte = TOK_PAD;
            SRC_RAW:     emit_byte = raw_reg;
            SRC_CNT:     emit_byte = {5'd0, cnt};
            default:     emit_byte = TOK_ABS;
        endcase

        out_free = !out_valid_reg || out_ready;
        capped   = (run_cnt_reg == MAX_RUN);
        push     = cmd.emit && !capped && (!pend_valid_reg || out_free);
        do_flush = cmd.flush && pend_valid_reg && out_free;

        run_cnt_next    = run_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_fin_next   = pend_fin_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_fin_next    = out_fin_reg;

        if (cmd.load)
            run_cnt_next = 4'd0;

        // Hold the newest byte back until we know whether it ends the run
        if (push)
        begin
            run_cnt_next    = run_cnt_reg + 4'd1;
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
            pend_fin_next   = cmd.fin;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
                out_fin_next   = pend_fin_reg;
            end
        end
        else if (do_flush)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            out_fin_next    = pend_fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG;
            acc_reg        <= 16'd0;
            left_reg       <= LEN_TAG;
            code_reg       <= 4'd0;
            atype_reg      <= 2'd0;
            name_reg       <= 3'd0;
            raw_reg        <= 8'd0;
            stopped_reg    <= 1'b0;
            run_cnt_reg    <= 4'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            left_reg       <= left_next;
            code_reg       <= code_next;
            atype_reg      <= atype_next;
            name_reg       <= name_next;
            raw_reg        <= raw_next;
            stopped_reg    <= stopped_next;
            run_cnt_reg    <= run_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fld_reg       <= fld_next;
        pend_byte_reg <= pend_byte_next;
        pend_fin_reg  <= pend_fin_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_fin_reg   <= out_fin_next;
    end

    assign stat.stopped  = stopped_reg;
    assign stat.emit_ok  = capped || !pend_valid_reg || out_free;
    assign stat.flush_ok = !pend_valid_reg || out_free;
    assign stat.seq      = seq;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign finished    = out_fin_reg;

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("end-of-file flag cleared");

    a_cap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (capped && !cmd.load) |=> capped)
        else $error("run count moved past its limit");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        do_flush |=> (out_valid_reg && out_last_reg && !pend_valid_reg))
        else $error("flushed item not marked last of run");

    a_push_keeps_pend: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (pend_valid_reg && run_cnt_reg != 4'd0))
        else $error("emitted byte lost from hold stage");

endmodule

`default_nettype wire

// File: src/rbe_ctrl.sv
`default_nettype none

module rbe_ctrl
    import rbe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [2:0] bit_reg, bit_next;
    seq_t       seq_reg, seq_next;
    logic [2:0] idx_reg, idx_next;

    logic [2:0] last_idx;
    src_t       src;

    function automatic logic [2:0] seq_last(input seq_t s);
        case (s)
            SEQ_REL, SEQ_CTRL, SEQ_END: seq_last = 3'd1;
            SEQ_AVAL:                   seq_last = 3'd2;
            SEQ_PAD:                    seq_last = 3'd5;
            default:                    seq_last = 3'd0;
        endcase
    endfunction

    function automatic src_t seq_src(input seq_t s, input logic [2:0] i);
        src_t r;
        r = SRC_LO;
        case (s)
            SEQ_ZERO: r = SRC_ZERO;
            SEQ_REL:  r = (i == 3'd0) ? SRC_HI : SRC_LO;
            SEQ_CTRL, SEQ_END:
                r = (i == 3'd0) ? SRC_SPECIAL : SRC_LO;
            SEQ_AVAL, SEQ_PAD:
            begin
                case (i)
                    3'd0:    r = SRC_ATYPE;
                    3'd1:    r = SRC_HI;
                    3'd2:    r = SRC_LO;
                    3'd3:    r = SRC_PAD;
                    3'd4:    r = SRC_RAW;
                    default: r = SRC_CNT;
                endcase
            end
            default:  r = SRC_LO;
        endcase
        seq_src = r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= 3'd0;
            seq_reg   <= SEQ_NONE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            seq_reg   <= seq_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        seq_next   = seq_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        last_idx   = seq_last(seq_reg);
        src        = seq_src(seq_reg, idx_reg);

        cmd         = '0;
        cmd.bit_sel = bit_reg;
        cmd.src     = src;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // Drop items once the end-of-file code has gone out
                if (in_valid && !stat.stopped)
                begin
                    cmd.load   = 1'b1;
                    bit_next   = 3'd0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (stat.seq != SEQ_NONE)
                begin
                    seq_next   = stat.seq;
                    idx_next   = 3'd0;
                    state_next = ST_EMIT;
                end
                else if (bit_reg == LAST_BIT)
                    state_next = ST_FLUSH;
                else
                    bit_next = bit_reg + 3'd1;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                cmd.fin  = (seq_reg == SEQ_END) && (idx_reg == last_idx);
                if (stat.emit_ok)
                begin
                    if (idx_reg != last_idx)
                        idx_next = idx_reg + 3'd1;
                    else if (seq_reg == SEQ_END || seq_reg == SEQ_PAD)
                        state_next = ST_FLUSH;
                    else if (bit_reg == LAST_BIT)
                        state_next = ST_FLUSH;
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        state_next = ST_STEP;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (stat.flush_ok)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/rel_bitstream_expander.sv
// Relocatable object bitstream expander.
// Input channel in_valid/in_ready/in_byte carries raw object file bytes; the
// bits are parsed most significant first. Output channel out_valid/out_ready
// carries out_byte with last_of_run (last token caused by that input item)
// and finished (set on the end-of-file control code token).
// An item is taken only while the sequencer is idle. Each item then has its
// bits parsed one per step (8, fewer after a padding or end-of-file code); each
// completed field raises tokens that the emitter sends one token a cycle while
// the receiver keeps up, at most six per field (from a padding code), and a
// final flush releases the last token before the next item can be taken.
// Tokens pass through a one-deep hold stage and an output register; a token
// leaves the hold stage only when the next token arrives or the item is done,
// and shows on the output the cycle after. The next input item can be taken
// while the last token still waits in the output register.
// If the receiver stalls, emission pauses with its state held; nothing is lost.
// At most eight tokens are delivered per input item; extra ones are dropped.
// After the end-of-file code every further input item is taken and ignored.
// Reset (rst_n low, asynchronous) returns the parser to expecting a tag bit,
// empties the hold and output stages and clears the end-of-file flag.
`default_nettype none

module rel_bitstream_expander
    import rbe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            finished
);

    cmd_t  cmd;
    stat_t stat;

    rbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbe_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .finished    (finished)
    );

endmodule

`default_nettype wire
